// ----- rtl/core/mscm_pkg.sv -----
package mscm_pkg;

    localparam int CH_FIELD_W  = 5;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int PHASE_W     = 32;
    localparam int TSEL_W      = 5;
    localparam int ENTRY_W     = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN        = 2'd0,
        CFG_TUNE_SELECT = 2'd1,
        CFG_TUNE_VALUE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [SAMPLE_W-1:0]   sample;
        logic                  in_range;
    } mscm_item_t;

    typedef struct packed {
        logic                  we;
        logic [TSEL_W-1:0]     sel;
        logic [PHASE_W-1:0]    value;
    } mscm_tune_wr_t;

    // Quarter-wave entry k: round(32767 * sin((2k+1) * pi / 2^table_bits)), Taylor series in Q30.
    function automatic logic [ENTRY_W-1:0] rom_entry(int unsigned k, int unsigned table_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned scaled;
        x    = ((2 * longint'(k) + 1) * 64'd1686629713) >> (table_bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        scaled = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
        return ENTRY_W'(scaled);
    endfunction

endpackage

// ----- rtl/core/mscm_sine_rom.sv -----
module mscm_sine_rom
    import mscm_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [SINE_TABLE_BITS-1:0] angle,
    output logic [ENTRY_W-1:0]         entry,
    output logic                       negate
);

    localparam int IDX_W   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << IDX_W;

    logic [ENTRY_W-1:0] rom_table [QUARTER];
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rom_addr;
    logic [ENTRY_W-1:0] entry_reg;
    logic               negate_reg;

    for (genvar k = 0; k < QUARTER; k++) begin : g_rom
        localparam logic [ENTRY_W-1:0] ENTRY = rom_entry(k, SINE_TABLE_BITS);
        assign rom_table[k] = ENTRY;
    end

    assign idx      = angle[IDX_W-1:0];
    // mirror in odd quadrants
    assign rom_addr = angle[IDX_W] ? ~idx : idx;

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg  <= rom_table[rom_addr];
            negate_reg <= angle[IDX_W+1];
        end
    end

    assign entry  = entry_reg;
    assign negate = negate_reg;

endmodule

// ----- rtl/core/mscm_state.sv -----
module mscm_state
    import mscm_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [CH_FIELD_W-1:0] in_channel,
    input  logic [SAMPLE_W-1:0]   in_sample,
    input  mscm_tune_wr_t      tune_wr,
    output logic               s1_valid,
    output mscm_item_t         s1_item,
    output logic [PHASE_W-1:0] phase_eff
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = CH_W + 6;

    logic [PHASE_W-1:0] phase_mem [CHANNELS];
    logic [PHASE_W-1:0] tune_mem  [CHANNELS];
    logic [CHANNELS-1:0] phase_vld_reg;
    logic [CHANNELS-1:0] tune_vld_reg;

    logic [PHASE_W-1:0] phase_rd_reg;
    logic [PHASE_W-1:0] tune_rd_reg;
    logic               pvld_rd_reg;
    logic               tvld_rd_reg;
    logic               fwd_hit_reg;
    logic [PHASE_W-1:0] fwd_phase_reg;
    logic               s1_valid_reg;
    mscm_item_t         s1_item_reg;

    logic               accept;
    logic [CMP_W-1:0]   rd_ext;
    logic [CH_W-1:0]    rd_addr;
    logic               rd_in_range;
    logic [CMP_W-1:0]   s1_ext;
    logic [CH_W-1:0]    s1_addr;
    logic [CMP_W-1:0]   tsel_ext;
    logic [CH_W-1:0]    tune_addr;
    logic               tune_we;
    logic               phase_we;
    logic               fwd_hit_next;
    logic [PHASE_W-1:0] tune_eff;
    logic [PHASE_W-1:0] phase_sum;

    assign accept      = adv && in_valid;
    assign rd_ext      = CMP_W'(in_channel);
    assign rd_addr     = rd_ext[CH_W-1:0];
    assign rd_in_range = rd_ext < CMP_W'(CHANNELS);
    assign s1_ext      = CMP_W'(s1_item_reg.channel);
    assign s1_addr     = s1_ext[CH_W-1:0];
    assign tsel_ext    = CMP_W'(tune_wr.sel);
    assign tune_addr   = tsel_ext[CH_W-1:0];
    assign tune_we     = tune_wr.we && (tsel_ext < CMP_W'(CHANNELS));

    assign phase_we     = adv && s1_valid_reg && s1_item_reg.in_range;
    assign fwd_hit_next = accept && phase_we && (s1_item_reg.channel == in_channel);

    // take the value being written back when the previous item hits the same channel
    assign phase_eff = fwd_hit_reg ? fwd_phase_reg : (pvld_rd_reg ? phase_rd_reg : '0);
    assign tune_eff  = tvld_rd_reg ? tune_rd_reg : '0;
    assign phase_sum = phase_eff + tune_eff;

    always_ff @(posedge aclk) begin
        if (accept) begin
            phase_rd_reg <= phase_mem[rd_addr];
            tune_rd_reg  <= tune_mem[rd_addr];
        end
        if (phase_we) begin
            phase_mem[s1_addr] <= phase_sum;
        end
        if (tune_we) begin
            tune_mem[tune_addr] <= tune_wr.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pvld_rd_reg   <= rd_in_range && phase_vld_reg[rd_addr];
            tvld_rd_reg   <= rd_in_range && tune_vld_reg[rd_addr];
            fwd_phase_reg <= phase_sum;
            s1_item_reg   <= '{channel: in_channel, sample: in_sample, in_range: rd_in_range};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_vld_reg <= '0;
            tune_vld_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            if (phase_we) begin
                phase_vld_reg[s1_addr] <= 1'b1;
            end
            if (tune_we) begin
                tune_vld_reg[tune_addr] <= 1'b1;
            end
            if (adv) begin
                s1_valid_reg <= in_valid;
                fwd_hit_reg  <= fwd_hit_next;
            end
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

`ifndef SYNTHESIS
    a_fwd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward flag without a live item");

    a_fwd_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_we && s1_item_reg.channel == in_channel) |=> fwd_hit_reg)
        else $error("same-channel hazard not forwarded");

    a_phase_vld: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_we |=> phase_vld_reg[$past(s1_addr)])
        else $error("phase entry not marked written");
`endif

endmodule

// ----- rtl/core/multichannel_sine_carrier_modulator.sv -----
// Per-channel NCO ring modulator: each item (channel in tuser, Q1.15 sample in tdata) is
// multiplied by the sine of that channel's 32-bit phase and by the Q4.12 gain, rounded half up
// and saturated to Q1.15, with the clip flag in m_tuser[5]. The channel's phase then advances by
// its tuning word. Phases and tuning words sit in two memories with registered reads; the phase
// add and write-back use the registered read as the item leaves that stage, and a one-deep forward
// covers back-to-back items on the same channel, so one item per cycle is sustained while the
// output is not stalled. After the memory read at acceptance come the sine table, two multiplies
// and round/clip. The whole pipeline stalls while a result waits on m_tready.
// Per-entry written flags replace a clearing pass, so items are taken right after reset.
// Write configuration only while idle.
module multichannel_sine_carrier_modulator
    import mscm_pkg::*;
#(
    parameter int CHANNELS        = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [15:0] sample
    input  logic [4:0]             s_tuser,   // [4:0] channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] product
    output logic [5:0]             m_tuser,   // [4:0] out_channel, [5] saturated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RAW_W = 2 * SAMPLE_W;
    localparam int P_W   = RAW_W + GAIN_W;
    localparam int B_W   = P_W + 1;
    localparam int R_W   = B_W - 27;

    logic [GAIN_W-1:0]  gain_reg;
    logic [TSEL_W-1:0]  tune_select_reg;

    logic               adv;
    logic               cfg_we;
    mscm_tune_wr_t      tune_wr;
    logic               s1_valid;
    mscm_item_t         s1_item;
    logic [PHASE_W-1:0] phase_eff;
    logic [ENTRY_W-1:0] rom_entry_q;
    logic               rom_negate;

    logic               s2_valid_reg;
    mscm_item_t         s2_item_reg;
    logic               s3_valid_reg;
    mscm_item_t         s3_item_reg;
    logic signed [RAW_W-1:0] s3_prod_reg;
    logic               s4_valid_reg;
    mscm_item_t         s4_item_reg;
    logic signed [P_W-1:0] s4_p_reg;

    logic               m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic [CH_FIELD_W-1:0] m_chan_reg;
    logic               m_sat_reg;

    logic signed [SAMPLE_W-1:0] sine;
    logic signed [RAW_W-1:0]    s3_prod_next;
    logic signed [P_W-1:0]      s4_p_next;
    logic signed [B_W-1:0]      biased;
    logic signed [R_W-1:0]      rounded;
    logic [SAMPLE_W-1:0]        m_data_next;
    logic                       m_sat_next;

    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign tune_wr = '{we: cfg_we && (cfg_index == CFG_TUNE_VALUE),
                       sel: tune_select_reg,
                       value: cfg_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= GAIN_RESET;
            tune_select_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_TUNE_SELECT: tune_select_reg <= cfg_data[TSEL_W-1:0];
                default:         ;
            endcase
        end
    end

    mscm_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_channel (s_tuser[CH_FIELD_W-1:0]),
        .in_sample  (s_tdata[SAMPLE_W-1:0]),
        .tune_wr    (tune_wr),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .phase_eff  (phase_eff)
    );

    mscm_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .aclk   (aclk),
        .en     (adv),
        .angle  (phase_eff[PHASE_W-1 -: SINE_TABLE_BITS]),
        .entry  (rom_entry_q),
        .negate (rom_negate)
    );

    assign sine = rom_negate ? -$signed({1'b0, rom_entry_q}) : $signed({1'b0, rom_entry_q});
    assign s3_prod_next = $signed(s2_item_reg.sample) * sine;
    assign s4_p_next    = s3_prod_reg * $signed(gain_reg);

    // round half up at bit 27, then clip to Q1.15
    assign biased  = B_W'(s4_p_reg) + (B_W'(1) <<< 26);
    assign rounded = R_W'(biased >>> 27);

    always_comb begin
        m_data_next = rounded[SAMPLE_W-1:0];
        m_sat_next  = 1'b0;
        if (!s4_item_reg.in_range) begin
            m_data_next = '0;
        end else if (rounded > R_W'(32767)) begin
            m_data_next = 16'h7fff;
            m_sat_next  = 1'b1;
        end else if (rounded < -R_W'(32768)) begin
            m_data_next = 16'h8000;
            m_sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item;
            s3_item_reg <= s2_item_reg;
            s3_prod_reg <= s3_prod_next;
            s4_item_reg <= s3_item_reg;
            s4_p_reg    <= s4_p_next;
            m_data_reg  <= m_data_next;
            m_chan_reg  <= s4_item_reg.channel;
            m_sat_reg   <= m_sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_sat_reg, m_chan_reg};

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[5]) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
        else $error("clip flag on unclipped product");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ----- tb/sv/multichannel_sine_carrier_modulator_test.sv -----
module multichannel_sine_carrier_modulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mscm_pkg::*;

    localparam int CHANNELS    = 32;
    localparam int TABLE_BITS  = 10;
    localparam int QUARTER     = 1 << (TABLE_BITS - 2);
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 220;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel;
        logic signed [SAMPLE_W-1:0] audio;
    } audio_item_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic signed [15:0]    level;
        logic                  clipped;
    } carrier_out_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;
    logic [4:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;
    logic [5:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [PHASE_W-1:0]       phase_acc[CHANNELS];
    logic [PHASE_W-1:0]       tuning_word[CHANNELS];
    logic signed [GAIN_W-1:0] gain_q412;
    logic [TSEL_W-1:0]        tune_sel;
    int unsigned              quarter_sine[QUARTER];

    audio_item_t  sample_queue[$];
    carrier_out_t product_queue[$];
    audio_item_t  next_item;
    carrier_out_t want;

    logic sender_idles   = 1'b1;
    logic receiver_idles = 1'b1;
    int   tx_gap         = 0;
    int   rx_stall       = 0;
    int   rx_draw        = 0;
    int   hold_requests  = 0;
    int   holds_granted  = 0;
    int   errors         = 0;
    int   cycle_count    = 0;

    multichannel_sine_carrier_modulator #(
        .CHANNELS       (CHANNELS),
        .SINE_TABLE_BITS(TABLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned sine_entry(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          acc;
        x    = (64'(2 * k + 1) * 64'd1686629713) >> (TABLE_BITS - 1);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        scaled = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[31:0];
    endfunction

    function automatic int sine_of_phase(logic [PHASE_W-1:0] ph);
        logic [TABLE_BITS-1:0] a;
        logic [1:0]            quad;
        int unsigned           idx;
        int                    v;
        a    = ph[PHASE_W-1 -: TABLE_BITS];
        quad = a[TABLE_BITS-1 -: 2];
        idx  = a[TABLE_BITS-3:0];
        v    = quad[0] ? int'(quarter_sine[QUARTER-1-idx]) : int'(quarter_sine[idx]);
        return quad[1] ? -v : v;
    endfunction

    function automatic carrier_out_t modulate(audio_item_t it);
        carrier_out_t res;
        longint       p;
        longint       r;
        p = longint'(it.audio) * longint'(sine_of_phase(phase_acc[it.channel]))
            * longint'(gain_q412);
        r = (p + 64'sd67108864) >>> 27;
        res.channel = it.channel;
        res.clipped = 1'b0;
        if (r > 32767) begin
            r = 32767;
            res.clipped = 1'b1;
        end else if (r < -32768) begin
            r = -32768;
            res.clipped = 1'b1;
        end
        res.level = r[15:0];
        phase_acc[it.channel] = phase_acc[it.channel] + tuning_word[it.channel];
        return res;
    endfunction

    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int expected_val, int actual_val);
        errors++;
        if (errors <= 50) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, expected_val, actual_val);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN: begin
                gain_q412 = data[GAIN_W-1:0];
            end
            CFG_TUNE_SELECT: begin
                tune_sel = data[TSEL_W-1:0];
            end
            CFG_TUNE_VALUE: begin
                tuning_word[tune_sel] = data;
            end
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(int ch, logic [15:0] lvl);
        sample_queue.push_back(audio_item_t'{5'(ch), lvl});
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || product_queue.size() != 0);
    endtask

    // sender: predict on acceptance, then hold, idle or offer the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                product_queue.push_back(modulate(audio_item_t'{s_tuser, s_tdata}));
            end
            if (s_tvalid && !s_tready) begin
            end else if (tx_gap != 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                next_item = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.channel;
                s_tdata  <= next_item.audio;
                tx_gap   <= sender_idles ? draw_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each result, then stall or accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (product_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, actual channel %0d level %0d",
                             $time, m_tuser[4:0], $signed(m_tdata));
                end else begin
                    want = product_queue.pop_front();
                    if (m_tuser[4:0] != want.channel) begin
                        report_mismatch("out_channel", want.channel, m_tuser[4:0]);
                    end
                    if (m_tdata != want.level) begin
                        report_mismatch("product", want.level, $signed(m_tdata));
                    end
                    if (m_tuser[5] != want.clipped) begin
                        report_mismatch("saturated", want.clipped, m_tuser[5]);
                    end
                end
            end
            if (rx_stall != 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else if (hold_requests != holds_granted) begin
                holds_granted <= holds_granted + 1;
                rx_stall      <= LONG_HOLD;
                m_tready      <= 1'b0;
            end else if (receiver_idles) begin
                rx_draw = draw_gap();
                m_tready <= (rx_draw == 0);
                rx_stall <= (rx_draw == 0) ? 0 : rx_draw - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int          ch_a;
        int          ch_b;
        int          ch;
        logic [15:0] lvl;
        logic [15:0] g;
        for (int k = 0; k < QUARTER; k++) begin
            quarter_sine[k] = sine_entry(k);
        end
        for (int c = 0; c < CHANNELS; c++) begin
            phase_acc[c]   = '0;
            tuning_word[c] = '0;
        end
        gain_q412 = GAIN_RESET;
        tune_sel  = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero tuning, unity gain
        push_item(0, 16'h7FFF);
        push_item(31, 16'h8000);
        push_item(5, 16'h0000);
        push_item(0, 16'hFFFF);
        wait_idle();

        // quarter-turn, full-scale and odd tunings; negative full-scale gain
        write_reg(CFG_TUNE_SELECT, 32'd0);
        write_reg(CFG_TUNE_VALUE, 32'h4000_0000);
        write_reg(CFG_TUNE_SELECT, 32'd31);
        write_reg(CFG_TUNE_VALUE, 32'hFFFF_FFFF);
        write_reg(CFG_TUNE_SELECT, 32'd7);
        write_reg(CFG_TUNE_VALUE, 32'hC000_0001);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        write_reg(CFG_GAIN, 32'h0000_8000);
        push_item(0, 16'h7FFF);
        push_item(0, 16'h8000);
        push_item(0, 16'h7FFF);
        push_item(0, 16'h8000);
        push_item(0, 16'h0001);
        push_item(31, 16'h8000);
        push_item(31, 16'h7FFF);
        push_item(31, 16'h0000);
        push_item(7, 16'h7FFF);
        push_item(7, 16'h8000);
        push_item(7, 16'hFFFF);
        wait_idle();

        write_reg(CFG_GAIN, 32'h0000_7FFF);
        push_item(0, 16'h7FFF);
        push_item(0, 16'h8000);
        push_item(7, 16'h7FFF);
        push_item(7, 16'h8000);
        wait_idle();

        write_reg(CFG_GAIN, 32'h0000_0000);
        push_item(31, 16'h7FFF);
        push_item(7, 16'h8000);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            sender_idles   = (ph != 1 && ph != 3);
            receiver_idles = (ph != 1);
            if ($urandom_range(0, 1) == 1) begin
                g = 16'($urandom);
            end else begin
                g = 16'($urandom_range(0, 8191) - 4096);
            end
            write_reg(CFG_GAIN, {16'($urandom), g});
            repeat ($urandom_range(2, 8)) begin
                write_reg(CFG_TUNE_SELECT, $urandom);
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(CFG_TUNE_VALUE, $urandom);
                end else begin
                    write_reg(CFG_TUNE_VALUE, $urandom_range(0, 32'h00FF_FFFF));
                end
            end
            ch_a = $urandom_range(0, CHANNELS - 1);
            ch_b = $urandom_range(0, CHANNELS - 1);
            if (ph == 3) begin
                hold_requests++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                if ($urandom_range(0, 99) < 30) begin
                    ch = ($urandom_range(0, 1) == 1) ? ch_a : ch_b;
                end else begin
                    ch = $urandom_range(0, CHANNELS - 1);
                end
                if ($urandom_range(0, 99) < 10) begin
                    case ($urandom_range(0, 3))
                        0: lvl = 16'h7FFF;
                        1: lvl = 16'h8000;
                        2: lvl = 16'h0000;
                        default: lvl = 16'hFFFF;
                    endcase
                end else begin
                    lvl = 16'($urandom);
                end
                push_item(ch, lvl);
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0 && product_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
